/* hw/rtl/gcsv_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcsv_pkg
// Shared types, opcodes, error codes and the protected register map of the
// GPU command stream validator.
// ----------------------------------------------------------------------------
package gcsv_pkg;

  localparam int MAX_WORDS   = 65536;
  localparam int WORD_CAP_I  = (MAX_WORDS < 131071) ? MAX_WORDS : 131071;
  localparam logic [16:0] WORD_CAP = WORD_CAP_I[16:0];

  localparam int OPCODE_SHIFT = 27;

  localparam logic [4:0] OP_LOAD_STATE  = 5'd1;
  localparam logic [4:0] OP_NOP         = 5'd3;
  localparam logic [4:0] OP_DRAW_2D     = 5'd4;
  localparam logic [4:0] OP_DRAW        = 5'd5;
  localparam logic [4:0] OP_DRAW_INDEX  = 5'd6;
  localparam logic [4:0] OP_STALL       = 5'd9;

  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_OPCODE     = 3'd1;
  localparam logic [2:0] ERR_ZERO_COUNT = 3'd2;
  localparam logic [2:0] ERR_ADDR_WRITE = 3'd3;
  localparam logic [2:0] ERR_OVERFLOW   = 3'd4;

  // Protected registers as word offsets (byte address / 4) and run lengths.
  localparam int NUM_RUNS = 24;
  localparam logic [16:0] PROT_BASE [NUM_RUNS] = '{
    17'h00480, 17'h0048A, 17'h0048E, 17'h004A1, 17'h004A3, 17'h004C1,
    17'h004C4, 17'h004C6, 17'h04A00, 17'h04A28, 17'h04A30, 17'h04A5C,
    17'h04A80, 17'h04AD0, 17'h04AE0, 17'h04B38, 17'h00504, 17'h0050C,
    17'h00516, 17'h00518, 17'h00540, 17'h00582, 17'h00584, 17'h005B0
  };
  localparam logic [16:0] PROT_LEN [NUM_RUNS] = '{
    17'd1, 17'd1, 17'd1, 17'd1, 17'd1, 17'd1, 17'd1, 17'd1,
    17'd4, 17'd4, 17'd4, 17'd4, 17'd8, 17'd8, 17'd8, 17'd8,
    17'd1, 17'd1, 17'd1, 17'd16, 17'd16, 17'd1, 17'd1, 17'd16
  };

  typedef struct packed {
    logic        op_bad;
    logic        cnt_zero;
    logic        is_load;
    logic [9:0]  remaining;
    logic [9:0]  data_cnt;
    logic [15:0] offset;
    logic        prot_hit;
    logic        word_nz;
  } dec_t;

  typedef struct packed {
    logic        accepted;
    logic [2:0]  error_code;
    logic [15:0] error_position;
    logic [16:0] words_seen;
  } verdict_t;

  function automatic logic is_protected(logic [16:0] off);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < NUM_RUNS; i++) begin
      if (off >= PROT_BASE[i] && off < PROT_BASE[i] + PROT_LEN[i]) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

/* hw/rtl/gcsv_decode.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcsv_decode
// Header decode of one command word and protected-offset lookup.
// ----------------------------------------------------------------------------
module gcsv_decode (
  input  logic [31:0]          word,
  input  logic [16:0]          reg_offset,
  output gcsv_pkg::dec_t       dec
);
  import gcsv_pkg::*;

  logic [4:0] opcode;
  logic [9:0] cnt;
  logic [7:0] n2d;

  assign opcode = word[31:OPCODE_SHIFT];
  assign cnt    = word[25:16];
  assign n2d    = word[15:8];

  always_comb begin
    dec           = '0;
    dec.offset    = word[15:0];
    dec.data_cnt  = cnt;
    dec.prot_hit  = is_protected(reg_offset);
    dec.word_nz   = (word != 32'd0);
    // remaining = (length rounded up to even) - 1
    case (opcode)
      OP_LOAD_STATE: begin
        dec.is_load   = 1'b1;
        dec.cnt_zero  = (cnt == 10'd0);
        dec.remaining = cnt | 10'd1;
      end
      OP_NOP, OP_STALL: dec.remaining = 10'd1;
      OP_DRAW_2D:       dec.remaining = {1'b0, n2d, 1'b1};
      OP_DRAW:          dec.remaining = 10'd3;
      OP_DRAW_INDEX:    dec.remaining = 10'd5;
      default:          dec.op_bad    = 1'b1;
    endcase
  end

endmodule

/* hw/rtl/gcsv_tracker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcsv_tracker
// Buffer state: word count, command progress, first error; forms the verdict
// on the last word and clears itself for the next buffer.
// ----------------------------------------------------------------------------
module gcsv_tracker (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  req_take,
  input  logic                  req_last,
  input  gcsv_pkg::dec_t        dec,
  output logic [16:0]           reg_offset,
  output logic                  verdict_vld,
  output gcsv_pkg::verdict_t    verdict
);
  import gcsv_pkg::*;

  logic [16:0] word_index_r,  word_index_nxt;
  logic [9:0]  remaining_r,   remaining_nxt;
  logic [9:0]  data_left_r,   data_left_nxt;
  logic [16:0] reg_offset_r,  reg_offset_nxt;
  logic [2:0]  first_err_r,   first_err_nxt;
  logic [15:0] fail_idx_r,    fail_idx_nxt;
  logic [15:0] cur_hdr_r,     cur_hdr_nxt;
  logic [15:0] pos16;
  logic        overflow;

  assign reg_offset = reg_offset_r;
  assign pos16      = word_index_r[16] ? 16'hFFFF : word_index_r[15:0];

  always_comb begin
    word_index_nxt = word_index_r;
    remaining_nxt  = remaining_r;
    data_left_nxt  = data_left_r;
    reg_offset_nxt = reg_offset_r;
    first_err_nxt  = first_err_r;
    fail_idx_nxt   = fail_idx_r;
    cur_hdr_nxt    = cur_hdr_r;

    if (word_index_r < WORD_CAP) begin
      word_index_nxt = word_index_r + 17'd1;
    end

    if (first_err_r == ERR_NONE) begin
      if (remaining_r == 10'd0) begin
        cur_hdr_nxt   = pos16;
        data_left_nxt = 10'd0;
        if (dec.op_bad) begin
          first_err_nxt = ERR_OPCODE;
          fail_idx_nxt  = pos16;
        end else if (dec.cnt_zero) begin
          first_err_nxt = ERR_ZERO_COUNT;
          fail_idx_nxt  = pos16;
        end else begin
          remaining_nxt = dec.remaining;
          if (dec.is_load) begin
            data_left_nxt  = dec.data_cnt;
            reg_offset_nxt = {1'b0, dec.offset};
          end
        end
      end else begin
        if (data_left_r != 10'd0) begin
          if (dec.word_nz && dec.prot_hit) begin
            first_err_nxt = ERR_ADDR_WRITE;
            fail_idx_nxt  = cur_hdr_r;
          end
          data_left_nxt  = data_left_r - 10'd1;
          reg_offset_nxt = reg_offset_r + 17'd1;
        end
        remaining_nxt = remaining_r - 10'd1;
      end
    end
  end

  // command cut off by the end of the buffer
  assign overflow = (first_err_nxt == ERR_NONE) && (remaining_nxt != 10'd0);

  always_comb begin
    verdict_vld = req_take && req_last;
    if (overflow) begin
      verdict.accepted       = 1'b0;
      verdict.error_code     = ERR_OVERFLOW;
      verdict.error_position = cur_hdr_nxt;
    end else begin
      verdict.accepted       = (first_err_nxt == ERR_NONE);
      verdict.error_code     = first_err_nxt;
      verdict.error_position = (first_err_nxt == ERR_NONE) ? 16'd0 : fail_idx_nxt;
    end
    verdict.words_seen = word_index_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (req_take && req_last)) begin
      word_index_r <= '0;
      remaining_r  <= '0;
      data_left_r  <= '0;
      reg_offset_r <= '0;
      first_err_r  <= ERR_NONE;
      fail_idx_r   <= '0;
      cur_hdr_r    <= '0;
    end else if (req_take) begin
      word_index_r <= word_index_nxt;
      remaining_r  <= remaining_nxt;
      data_left_r  <= data_left_nxt;
      reg_offset_r <= reg_offset_nxt;
      first_err_r  <= first_err_nxt;
      fail_idx_r   <= fail_idx_nxt;
      cur_hdr_r    <= cur_hdr_nxt;
    end
  end

endmodule

/* hw/rtl/gcsv_out_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcsv_out_stage
// Result register holding one verdict until the consumer takes it.
// ----------------------------------------------------------------------------
module gcsv_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  gcsv_pkg::verdict_t   verdict,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic                 can_load,
  output gcsv_pkg::verdict_t   held
);
  import gcsv_pkg::*;

  logic     valid_r;
  verdict_t held_r;

  assign out_valid = valid_r;
  assign held      = held_r;
  assign can_load  = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held_r <= verdict;
    end
  end

endmodule

/* hw/rtl/gpu_command_stream_validator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpu_command_stream_validator
// Validates a stream of command words, one request per word; one verdict per
// buffer, issued in the cycle after the word marked last is accepted.
// Throughput: one word per cycle; the input stalls only while a verdict sits
// in the result register and the consumer is not ready.
// Reset (rst_n low, synchronous): buffer state cleared, result register empty.
// ----------------------------------------------------------------------------
module gpu_command_stream_validator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_command_word,
  input  logic        in_last_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_accepted,
  output logic [2:0]  out_error_code,
  output logic [15:0] out_error_position,
  output logic [16:0] out_words_seen
);
  import gcsv_pkg::*;

  dec_t        dec;
  verdict_t    verdict;
  verdict_t    held;
  logic [16:0] reg_offset;
  logic        verdict_vld;
  logic        can_load;
  logic        req_take;

  assign in_ready = can_load;
  assign req_take = in_valid && in_ready;

  gcsv_decode u_decode (
    .word       (in_command_word),
    .reg_offset (reg_offset),
    .dec        (dec)
  );

  gcsv_tracker u_tracker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_take    (req_take),
    .req_last    (in_last_word),
    .dec         (dec),
    .reg_offset  (reg_offset),
    .verdict_vld (verdict_vld),
    .verdict     (verdict)
  );

  gcsv_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (verdict_vld),
    .verdict   (verdict),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .can_load  (can_load),
    .held      (held)
  );

  assign out_accepted       = held.accepted;
  assign out_error_code     = held.error_code;
  assign out_error_position = held.error_position;
  assign out_words_seen     = held.words_seen;

endmodule

/* hw/rtl/gcsv_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcsv_checker
// Port-level checks on the validator's result channel.
// ----------------------------------------------------------------------------
module gcsv_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_last_word,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_accepted,
  input logic [2:0]  out_error_code,
  input logic [15:0] out_error_position,
  input logic [16:0] out_words_seen
);
  import gcsv_pkg::*;

  // a stalled verdict stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("verdict dropped while stalled");

  a_acc_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_accepted == (out_error_code == ERR_NONE)))
    else $error("accepted flag disagrees with error code");

  a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_accepted |-> out_error_position == 16'd0)
    else $error("error position set on a passing buffer");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_words_seen != 17'd0 && out_words_seen <= WORD_CAP)
    else $error("word count out of range");

  // a last word yields a verdict on the next cycle
  a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last_word |=> out_valid)
    else $error("no verdict after last word");

endmodule

bind gpu_command_stream_validator gcsv_checker u_gcsv_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .in_last_word       (in_last_word),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_accepted       (out_accepted),
  .out_error_code     (out_error_code),
  .out_error_position (out_error_position),
  .out_words_seen     (out_words_seen)
);
